// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/skfa_pkg.sv
// ---------------------------------------------------------------------------
// skfa_pkg
// Types, constants and the exponent program of the secp256k1 field unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package skfa_pkg;

    localparam int LIMB_W = 32;
    localparam int ACC_W  = 72;

    localparam logic [1:0] MODE_MUL  = 2'd0;
    localparam logic [1:0] MODE_INV  = 2'd1;
    localparam logic [1:0] MODE_SQRT = 2'd2;
    localparam logic [1:0] MODE_HALF = 2'd3;

    // Low 32 bits of the folding constant 2^32 + 977; the 2^32 part is a shift.
    localparam logic [LIMB_W-1:0] FOLD_LO = 32'h0000_03D1;
    localparam logic [255:0] FOLD_C  = 256'h1_0000_03D1;
    localparam logic [255:0] P_MOD   =
        {192'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF,
         64'hFFFF_FFFE_FFFF_FC2F};

    // Register file slots of the exponent program.
    localparam logic [2:0] SL_A    = 3'd0;
    localparam logic [2:0] SL_X2   = 3'd1;
    localparam logic [2:0] SL_X3   = 3'd2;
    localparam logic [2:0] SL_S    = 3'd3;
    localparam logic [2:0] SL_X22  = 3'd4;
    localparam logic [2:0] SL_X44  = 3'd5;
    localparam logic [2:0] SL_X223 = 3'd6;
    localparam logic [2:0] SL_R    = 3'd7;

    localparam logic [4:0] PC_HEAD_END  = 5'd10;
    localparam logic [4:0] PC_INV_END   = 5'd14;
    localparam logic [4:0] PC_SQRT_TAIL = 5'd15;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] a_limb0;
        logic [63:0] a_limb1;
        logic [63:0] a_limb2;
        logic [63:0] a_limb3;
        logic [63:0] b_limb0;
        logic [63:0] b_limb1;
        logic [63:0] b_limb2;
        logic [63:0] b_limb3;
    } in_word_t;

    typedef struct packed {
        logic [63:0] r_limb0;
        logic [63:0] r_limb1;
        logic [63:0] r_limb2;
        logic [63:0] r_limb3;
        logic        is_square;
    } out_word_t;

    // One step: square src n times, then, when has_mul is set, multiply by mul and store in dst.
    typedef struct packed {
        logic [2:0] src;
        logic [6:0] n;
        logic [2:0] mul;
        logic [2:0] dst;
        logic       has_mul;
    } prog_t;

    function automatic prog_t prog_entry(input logic [4:0] pc);
        prog_t e;
        case (pc)
            5'd0:    e = '{SL_A,    7'd1,  SL_A,   SL_X2,   1'b1};
            5'd1:    e = '{SL_X2,   7'd1,  SL_A,   SL_X3,   1'b1};
            5'd2:    e = '{SL_X3,   7'd3,  SL_X3,  SL_S,    1'b1};
            5'd3:    e = '{SL_S,    7'd3,  SL_X3,  SL_S,    1'b1};
            5'd4:    e = '{SL_S,    7'd2,  SL_X2,  SL_S,    1'b1};
            5'd5:    e = '{SL_S,    7'd11, SL_S,   SL_X22,  1'b1};
            5'd6:    e = '{SL_X22,  7'd22, SL_X22, SL_X44,  1'b1};
            5'd7:    e = '{SL_X44,  7'd44, SL_X44, SL_S,    1'b1};
            5'd8:    e = '{SL_S,    7'd88, SL_S,   SL_S,    1'b1};
            5'd9:    e = '{SL_S,    7'd44, SL_X44, SL_S,    1'b1};
            5'd10:   e = '{SL_S,    7'd3,  SL_X3,  SL_X223, 1'b1};
            5'd11:   e = '{SL_X223, 7'd23, SL_X22, SL_R,    1'b1};
            5'd12:   e = '{SL_R,    7'd5,  SL_A,   SL_R,    1'b1};
            5'd13:   e = '{SL_R,    7'd3,  SL_X2,  SL_R,    1'b1};
            5'd14:   e = '{SL_R,    7'd2,  SL_A,   SL_R,    1'b1};
            5'd15:   e = '{SL_X223, 7'd23, SL_X22, SL_R,    1'b1};
            5'd16:   e = '{SL_R,    7'd6,  SL_X2,  SL_R,    1'b1};
            5'd17:   e = '{SL_R,    7'd2,  SL_A,   SL_R,    1'b0};
            default: e = '{SL_A,    7'd0,  SL_A,   SL_R,    1'b0};
        endcase
        return e;
    endfunction

    // Full reduction of a value below 2^256: subtracting p is adding FOLD_C.
    function automatic logic [255:0] fe_norm(input logic [255:0] v);
        logic [255:0] r;
        r = (v >= P_MOD) ? (v + FOLD_C) : v;
        return r;
    endfunction

endpackage

// File: hw/rtl/skfa_mul.sv
// ---------------------------------------------------------------------------
// skfa_mul
// Field multiplier built around one 32x32 multiplier: column-wise product
// accumulation, then repeated folding of the high half by 2^32 + 977.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skfa_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] x,
    input  logic [255:0] y,
    output logic         done,
    output logic [255:0] res
);
    import skfa_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_MUL   = 5'b00010,
        M_MWAIT = 5'b00100,
        M_FOLD  = 5'b01000,
        M_FWAIT = 5'b10000
    } mstate_t;

    mstate_t state_reg, state_next;
    logic [3:0] k_reg, k_next;
    logic [2:0] i_reg, i_next;
    logic [2:0] f_reg, f_next;
    logic pv_reg, pv_next;
    logic pfold_reg, pfold_next;
    logic plast_reg, plast_next;
    logic pend_reg, pend_next;
    logic done_reg, done_next;

    logic [255:0] x_reg, x_next;
    logic [255:0] y_reg, y_next;
    logic [511:0] w_reg, w_next;
    logic [255:0] r_reg, r_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [63:0] p_reg, p_next;
    logic [LIMB_W-1:0] lo_reg, lo_next;
    logic [LIMB_W-1:0] hi_reg, hi_next;
    logic [LIMB_W-1:0] hprev_reg, hprev_next;

    logic [2:0] hi_i;
    logic [2:0] j_idx;
    logic col_last;
    logic [LIMB_W-1:0] ma, mb;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] carry_top;
    logic [255:0] r_shift;

    assign hi_i     = (k_reg > 4'd7) ? 3'd7 : k_reg[2:0];
    assign j_idx    = 3'(k_reg - {1'b0, i_reg});
    assign col_last = (i_reg == hi_i);

    always_comb
    begin
        if (state_reg == M_FOLD)
        begin
            ma = w_reg[287:256];
            mb = FOLD_LO;
        end
        else
        begin
            ma = x_reg[{i_reg, 5'b0} +: LIMB_W];
            mb = y_reg[{j_idx, 5'b0} +: LIMB_W];
        end
    end

    always_comb
    begin
        if (pfold_reg)
            sum = acc_reg + ACC_W'(p_reg) + ACC_W'(lo_reg) + ACC_W'(hprev_reg);
        else
            sum = acc_reg + ACC_W'(p_reg);
    end

    assign carry_top = (sum >> LIMB_W) + ACC_W'(hi_reg);
    assign r_shift   = {sum[LIMB_W-1:0], r_reg[255:LIMB_W]};

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        f_next     = f_reg;
        pv_next    = 1'b0;
        pfold_next = pfold_reg;
        plast_next = 1'b0;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        w_next     = w_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        p_next     = 64'(ma) * 64'(mb);
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        hprev_next = hprev_reg;

        // Issue side: one product enters the multiplier register per cycle.
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    x_next     = x;
                    y_next     = y;
                    k_next     = 4'd0;
                    i_next     = 3'd0;
                    acc_next   = '0;
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                pv_next    = 1'b1;
                pfold_next = 1'b0;
                plast_next = col_last;
                if (col_last)
                begin
                    k_next = k_reg + 4'd1;
                    i_next = (k_reg >= 4'd7) ? 3'(k_reg - 4'd6) : 3'd0;
                    if (k_reg == 4'd14)
                    begin
                        pend_next  = 1'b1;
                        state_next = M_MWAIT;
                    end
                end
                else
                begin
                    i_next = i_reg + 3'd1;
                end
            end
            M_FOLD:
            begin
                pv_next    = 1'b1;
                pfold_next = 1'b1;
                plast_next = (f_reg == 3'd7);
                lo_next    = w_reg[31:0];
                hi_next    = w_reg[287:256];
                w_next     = {32'b0, w_reg[511:288], 32'b0, w_reg[255:32]};
                f_next     = f_reg + 3'd1;
                if (f_reg == 3'd7)
                    state_next = M_FWAIT;
            end
            default:
            begin
            end
        endcase

        // Accumulate side: handles the product issued in the cycle before.
        if (pv_reg && !pfold_reg)
        begin
            if (plast_reg)
            begin
                acc_next = sum >> LIMB_W;
                if (pend_reg)
                begin
                    // The last column also leaves the top limb in the carry.
                    w_next     = {acc_next[LIMB_W-1:0], sum[LIMB_W-1:0], w_reg[511:64]};
                    acc_next   = '0;
                    hprev_next = '0;
                    f_next     = 3'd0;
                    state_next = M_FOLD;
                end
                else
                begin
                    w_next = {sum[LIMB_W-1:0], w_reg[511:LIMB_W]};
                end
            end
            else
            begin
                acc_next = sum;
            end
        end
        else if (pv_reg && pfold_reg)
        begin
            r_next     = r_shift;
            acc_next   = sum >> LIMB_W;
            hprev_next = hi_reg;
            if (plast_reg)
            begin
                if (carry_top == '0)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    // Fold the leftover carry back in with another pass.
                    w_next     = {208'b0, carry_top[47:0], r_shift};
                    acc_next   = '0;
                    hprev_next = '0;
                    f_next     = 3'd0;
                    state_next = M_FOLD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            f_reg     <= '0;
            pv_reg    <= 1'b0;
            pfold_reg <= 1'b0;
            plast_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            f_reg     <= f_next;
            pv_reg    <= pv_next;
            pfold_reg <= pfold_next;
            plast_reg <= plast_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        w_reg     <= w_next;
        r_reg     <= r_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        hprev_reg <= hprev_next;
    end

    assign done = done_reg;
    assign res  = r_reg;

    `AST_NEXT(a_done_pulse, done_reg, !done_reg)
    `AST_IMP(a_start_idle, start, state_reg == M_IDLE)

endmodule

// File: hw/rtl/secp256k1_field_alu.sv
// ---------------------------------------------------------------------------
// secp256k1_field_alu
// Multiply, invert, square root and halve modulo p = 2^256 - 2^32 - 977.
// ---------------------------------------------------------------------------
// One input word on in_data (valid/stall) gives one result word on out_data
// (valid/stall). The block takes one word at a time: in_stall is high from
// acceptance until the result has been loaded into the output register.
// Every field multiply runs on one shared 32x32 multiplier: 64 partial
// products plus one to three 8-step folding passes.
// Field multiplies per operation: halve uses none, multiply one,
// invert 270 and square root 267.
// The sequencer of the exponent chains, with its 8-entry register file of
// intermediate powers, sets the chain length. A finished result waits in the
// output register while out_stall is high; the next word is accepted as soon
// as the result has moved there. Reset returns the sequencer and multiplier
// to idle and drops out_valid; the data registers are not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module secp256k1_field_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  skfa_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output skfa_pkg::out_word_t out_data
);
    import skfa_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_FETCH = 11'b000_0000_0010,
        ST_LOAD  = 11'b000_0000_0100,
        ST_SQR   = 11'b000_0000_1000,
        ST_SQW   = 11'b000_0001_0000,
        ST_MUL   = 11'b000_0010_0000,
        ST_MULW  = 11'b000_0100_0000,
        ST_CHK   = 11'b000_1000_0000,
        ST_CHKW  = 11'b001_0000_0000,
        ST_CMP   = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] pc_reg, pc_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [1:0] mode_reg, mode_next;
    logic out_valid_reg, out_valid_next;

    logic [255:0] t_reg, t_next;
    logic [255:0] m_reg, m_next;
    logic [255:0] an_reg, an_next;
    logic [255:0] chk_reg, chk_next;
    logic [255:0] res_reg, res_next;
    logic sq_reg, sq_next;
    out_word_t out_reg, out_next;

    logic [255:0] rf_mem [8];
    logic [255:0] rd_src_reg, rd_mul_reg;
    logic rf_we;
    logic [2:0] rf_wa;
    logic [255:0] rf_wd;

    prog_t cur;
    logic [255:0] a_in, b_in, half_sum_lo;
    logic [256:0] half_sum;
    logic mul_start, mul_done;
    logic [255:0] mul_y, mul_res;
    logic use_m;

    assign cur  = prog_entry(pc_reg);
    assign a_in = {in_data.a_limb3, in_data.a_limb2, in_data.a_limb1, in_data.a_limb0};
    assign b_in = {in_data.b_limb3, in_data.b_limb2, in_data.b_limb1, in_data.b_limb0};

    // Halving adds p to an odd operand; the carry becomes bit 255.
    assign half_sum_lo = a_in[0] ? P_MOD : 256'b0;
    assign half_sum    = {1'b0, a_in} + {1'b0, half_sum_lo};

    assign use_m = (state_reg == ST_MUL) && (cur.has_mul || mode_reg == MODE_MUL);
    assign mul_y = use_m ? m_reg : t_reg;

    skfa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (t_reg),
        .y     (mul_y),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_wa] <= rf_wd;
        rd_src_reg <= rf_mem[cur.src];
        rd_mul_reg <= rf_mem[cur.mul];
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        t_next         = t_reg;
        m_next         = m_reg;
        an_next        = an_reg;
        chk_next       = chk_reg;
        res_next       = res_reg;
        sq_next        = sq_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        rf_we          = 1'b0;
        rf_wa          = SL_A;
        rf_wd          = t_reg;
        mul_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = in_data.mode;
                    t_next    = a_in;
                    m_next    = b_in;
                    an_next   = fe_norm(a_in);
                    pc_next   = 5'd0;
                    sq_next   = 1'b0;
                    rf_we     = 1'b1;
                    rf_wa     = SL_A;
                    rf_wd     = a_in;
                    case (in_data.mode)
                        MODE_MUL:
                            state_next = ST_MUL;
                        MODE_HALF:
                        begin
                            res_next   = half_sum[256:1];
                            state_next = ST_OUT;
                        end
                        default:
                            state_next = ST_FETCH;
                    endcase
                end
            end
            ST_FETCH:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                t_next     = rd_src_reg;
                m_next     = rd_mul_reg;
                cnt_next   = cur.n;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                if (cnt_reg == 7'd0)
                    state_next = ST_MUL;
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_SQW;
                end
            end
            ST_SQW:
            begin
                if (mul_done)
                begin
                    t_next     = mul_res;
                    cnt_next   = cnt_reg - 7'd1;
                    state_next = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (use_m)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MULW;
                end
                else
                begin
                    // Square root ends on plain squarings: t is the root.
                    res_next   = t_reg;
                    state_next = ST_CHK;
                end
            end
            ST_MULW:
            begin
                if (mul_done)
                begin
                    if (mode_reg == MODE_MUL)
                    begin
                        res_next   = mul_res;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rf_we = 1'b1;
                        rf_wa = cur.dst;
                        rf_wd = mul_res;
                        if (mode_reg == MODE_INV && pc_reg == PC_INV_END)
                        begin
                            res_next   = mul_res;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            if (mode_reg == MODE_SQRT && pc_reg == PC_HEAD_END)
                                pc_next = PC_SQRT_TAIL;
                            else
                                pc_next = pc_reg + 5'd1;
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_CHK:
            begin
                mul_start  = 1'b1;
                state_next = ST_CHKW;
            end
            ST_CHKW:
            begin
                if (mul_done)
                begin
                    chk_next   = fe_norm(mul_res);
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                sq_next    = (chk_reg == an_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.r_limb0   = res_reg[63:0];
                    out_next.r_limb1   = res_reg[127:64];
                    out_next.r_limb2   = res_reg[191:128];
                    out_next.r_limb3   = res_reg[255:192];
                    out_next.is_square = sq_reg;
                    out_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            mode_reg      <= MODE_MUL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        m_reg   <= m_next;
        an_reg  <= an_next;
        chk_reg <= chk_next;
        res_reg <= res_next;
        sq_reg  <= sq_next;
        out_reg <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `AST_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `AST_IMP(a_done_in_wait, mul_done,
        state_reg == ST_SQW || state_reg == ST_MULW || state_reg == ST_CHKW)

endmodule
